// ===== rtl/core/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg: shared definitions for the force/torque CAN wrench decoder
// Widths, CAN identifiers, register indexes, reset scales and the structs
// that pass between the frame front end, the axis lanes and the result queue.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int NUM_AXES      = 6;
    localparam int NUM_WORDS     = 3;
    localparam int ID_W          = 11;
    localparam int LEN_W         = 4;
    localparam int PAYLOAD_W     = 64;
    localparam int RAW_W         = 16;
    localparam int SCALE_W       = 16;
    localparam int OUT_W         = 25;
    // Centered raw word (16 bits signed) times zero-extended scale (17 bits).
    localparam int PROD_W        = RAW_W + SCALE_W + 1;
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 152;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Largest magnitude of any scaled or tared axis value.
    localparam int OUT_LIMIT     = 16776960;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [ID_W-1:0] FORCE_ID  = 11'h3DA;
    localparam logic [ID_W-1:0] TORQUE_ID = 11'h3DB;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORCE_SCALE_X  = 3'd0,
        REG_FORCE_SCALE_Y  = 3'd1,
        REG_FORCE_SCALE_Z  = 3'd2,
        REG_TORQUE_SCALE_X = 3'd3,
        REG_TORQUE_SCALE_Y = 3'd4,
        REG_TORQUE_SCALE_Z = 3'd5
    } t_reg_idx;

    localparam logic [SCALE_W-1:0] RESET_FORCE_SCALE_X  = 16'd1566;
    localparam logic [SCALE_W-1:0] RESET_FORCE_SCALE_Y  = 16'd1776;
    localparam logic [SCALE_W-1:0] RESET_FORCE_SCALE_Z  = 16'd2122;
    localparam logic [SCALE_W-1:0] RESET_TORQUE_SCALE_X = 16'd37;
    localparam logic [SCALE_W-1:0] RESET_TORQUE_SCALE_Y = 16'd37;
    localparam logic [SCALE_W-1:0] RESET_TORQUE_SCALE_Z = 16'd23;

    // Per-lane strobes from the front end.
    typedef struct packed {
        logic launch;   // a wrench enters the lane multiplier stage
        logic capture;  // the wrench leaving the rounding stage takes a new tare
    } t_lane_ctrl;

    // One finished wrench, axis 0 in the low bits.
    typedef struct packed {
        logic                               tare_taken;
        logic [NUM_AXES-1:0][OUT_W-1:0]     axis;
    } t_wrench;

endpackage

// ===== rtl/core/fts_lane.sv =====
// ----------------------------------------------------------------------------
// fts_lane: scaling and tare pipeline for one wrench axis
// Multiplies the centered raw word by the full scale, rounds and clamps,
// subtracts the stored tare, clamps again and optionally negates.
// ----------------------------------------------------------------------------
module fts_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fts_pkg::t_lane_ctrl            i_ctrl,
    input  logic [fts_pkg::RAW_W-1:0]      i_raw,
    input  logic [fts_pkg::SCALE_W-1:0]    i_scale,
    input  logic                           i_negate,
    output logic [fts_pkg::OUT_W-1:0]      o_value
);
    import fts_pkg::*;

    localparam int NUM_W  = PROD_W + FRACTION_BITS + 1;
    localparam int DIFF_W = OUT_W + 1;
    localparam logic signed [NUM_W-1:0]  ROUND_W  = NUM_W'(1 << 14);
    localparam logic signed [NUM_W-1:0]  LIM_N    = NUM_W'(OUT_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_D    = DIFF_W'(OUT_LIMIT);

    logic signed [RAW_W-1:0]   centered;
    logic signed [SCALE_W:0]   scale_s;
    logic signed [PROD_W-1:0]  n_prod,   r_prod;
    logic signed [NUM_W-1:0]   num,      shifted;
    logic signed [OUT_W-1:0]   n_scaled, r_scaled;
    logic signed [OUT_W-1:0]   r_tare;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [OUT_W-1:0]   tared;
    logic signed [OUT_W-1:0]   n_value,  r_value;

    // raw - 32768 is the raw word with its top bit flipped.
    assign centered = {~i_raw[RAW_W-1], i_raw[RAW_W-2:0]};
    assign scale_s  = {1'b0, i_scale};
    assign n_prod   = PROD_W'(centered) * PROD_W'(scale_s);

    // Round to nearest, ties toward plus infinity, then clamp.
    always_comb begin
        num     = (NUM_W'(r_prod) <<< FRACTION_BITS) + ROUND_W;
        shifted = num >>> 15;
        if (shifted > LIM_N) begin
            n_scaled = OUT_W'(OUT_LIMIT);
        end else if (shifted < -LIM_N) begin
            n_scaled = -OUT_W'(OUT_LIMIT);
        end else begin
            n_scaled = shifted[OUT_W-1:0];
        end
    end

    always_comb begin
        diff = DIFF_W'(r_scaled) - DIFF_W'(r_tare);
        if (diff > LIM_D) begin
            tared = OUT_W'(OUT_LIMIT);
        end else if (diff < -LIM_D) begin
            tared = -OUT_W'(OUT_LIMIT);
        end else begin
            tared = diff[OUT_W-1:0];
        end
        n_value = i_negate ? -tared : tared;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.launch) begin
            r_prod <= n_prod;
        end
        r_scaled <= n_scaled;
        r_value  <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare <= '0;
        end else if (i_ctrl.capture) begin
            r_tare <= r_scaled;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/core/fts_merge.sv =====
// ----------------------------------------------------------------------------
// fts_merge: result queue that gathers the six lane outputs
// Packs one wrench per entry and presents it on the master stream.
// ----------------------------------------------------------------------------
module fts_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  fts_pkg::t_wrench                   i_wrench,
    input  logic                               i_pop_ready,
    output logic                               o_valid,
    output logic [fts_pkg::OUT_DATA_W-1:0]     o_data,
    output logic [fts_pkg::FIFO_CNT_W-1:0]     o_count
);
    import fts_pkg::*;

    localparam int WR_W = $bits(t_wrench);

    t_wrench                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count,  n_count;
    logic                    pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_pop_ready;
    assign o_data  = {{(OUT_DATA_W - WR_W){1'b0}}, r_mem[r_rd_ptr]};
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + FIFO_CNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wrench;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == FIFO_CNT_W'(FIFO_DEPTH))))
        else $error("result queue written while full");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FIFO_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[FIFO_PTR_W-1:0]))
        else $error("queue pointers disagree with fill count");

    a_drop_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(pop))
        else $error("result vanished without being taken");
`endif

endmodule

// ===== rtl/core/ft_sensor_can_wrench_decoder.sv =====
// ----------------------------------------------------------------------------
// ft_sensor_can_wrench_decoder: six-axis force/torque wrench decoder
// Unpacks force and torque CAN frames and emits a scaled, tared wrench.
// ----------------------------------------------------------------------------
// The block takes one CAN frame request per clock cycle, without gaps, as
// long as its result queue has room. A force frame (identifier 0x3DA) or a
// torque frame (0x3DB) updates up to three raw 16-bit words, one word per two
// data bytes; any other identifier only latches a tare request. When both a
// force and a torque frame have been seen, six axis lanes work side by side:
// each multiplies (raw - 32768) by its full scale, rounds to 1/256 units and
// clamps, subtracts its tare and clamps again; x force and x torque come out
// negated. A wrench reaches the master stream after the frame that completes it
// by way of the three register stages of each lane (multiplier, rounding, tare
// subtract) and then the four-entry result queue.
// Input ready is computed from the queue fill count and the wrenches still
// in the lanes, so it never depends on the master tready in the same cycle;
// with the master side always ready the block sustains one frame per cycle.
// A tare request latches and is applied at the next emitted wrench: that
// wrench still carries the old tare and reports tare_taken, and its untared
// readings become the tare from then on. Scale registers are written through
// the configuration channel, which is always ready; indexes of six and above
// are ignored. Write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module ft_sensor_can_wrench_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream, tdata from bit 0 up: frame_id[10:0], frame_length[3:0],
    // payload[63:0], tare_request.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fts_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // Master stream, tdata from bit 0 up: force_x, force_y, force_z,
    // torque_x, torque_y, torque_z (25 bits signed each), tare_taken, one
    // zero pad bit.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fts_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fts_pkg::*;

    localparam int STAGES = 3;

    // Input fields.
    logic [ID_W-1:0]       frame_id;
    logic [LEN_W-1:0]      frame_length;
    logic [PAYLOAD_W-1:0]  payload;
    logic                  tare_request;

    assign frame_id     = i_s_tdata[ID_W-1:0];
    assign frame_length = i_s_tdata[ID_W+LEN_W-1:ID_W];
    assign payload      = i_s_tdata[ID_W+LEN_W+PAYLOAD_W-1:ID_W+LEN_W];
    assign tare_request = i_s_tdata[ID_W+LEN_W+PAYLOAD_W];

    // Scale registers, axis order matches the output fields.
    logic [NUM_AXES-1:0][SCALE_W-1:0] r_scale;

    // Frame state.
    logic [NUM_WORDS-1:0][RAW_W-1:0]  r_raw_force,  n_raw_force;
    logic [NUM_WORDS-1:0][RAW_W-1:0]  r_raw_torque, n_raw_torque;
    logic                             r_force_seen,  n_force_seen;
    logic                             r_torque_seen, n_torque_seen;
    logic                             r_tare_pending, n_tare_pending;

    // Wrench tracking through the lanes.
    logic [STAGES-1:0]                r_flight;
    logic [STAGES-1:0]                r_taken;

    logic                             accept;
    logic                             is_force, is_torque;
    logic [LEN_W-2:0]                 word_count;
    logic                             wrench;
    logic [1:0]                       in_lanes;
    logic [FIFO_CNT_W:0]              committed;
    logic [FIFO_CNT_W-1:0]            fifo_count;

    t_lane_ctrl                       lane_ctrl;
    t_wrench                          wrench_out;

    assign accept     = i_s_tvalid && o_s_tready;
    assign is_force   = (frame_id == FORCE_ID);
    assign is_torque  = (frame_id == TORQUE_ID);
    // Words present are half the length code; the word loop caps it at three.
    assign word_count = frame_length[LEN_W-1:1];

    always_comb begin
        n_raw_force  = r_raw_force;
        n_raw_torque = r_raw_torque;
        for (int i = 0; i < NUM_WORDS; i++) begin
            if (word_count > (LEN_W-1)'(i)) begin
                if (is_force) begin
                    n_raw_force[i] = payload[RAW_W*i +: RAW_W];
                end
                if (is_torque) begin
                    n_raw_torque[i] = payload[RAW_W*i +: RAW_W];
                end
            end
        end
        n_force_seen   = r_force_seen  || is_force;
        n_torque_seen  = r_torque_seen || is_torque;
        n_tare_pending = r_tare_pending || tare_request;
    end

    assign wrench = n_force_seen && n_torque_seen;

    // Every wrench still in a lane owns a queue slot, so the queue never
    // overflows and ready stays clear of the master side.
    assign in_lanes  = 2'(r_flight[0]) + 2'(r_flight[1]) + 2'(r_flight[2]);
    assign committed = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(in_lanes);
    assign o_s_tready = (committed < (FIFO_CNT_W+1)'(FIFO_DEPTH));

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale[REG_FORCE_SCALE_X]  <= RESET_FORCE_SCALE_X;
            r_scale[REG_FORCE_SCALE_Y]  <= RESET_FORCE_SCALE_Y;
            r_scale[REG_FORCE_SCALE_Z]  <= RESET_FORCE_SCALE_Z;
            r_scale[REG_TORQUE_SCALE_X] <= RESET_TORQUE_SCALE_X;
            r_scale[REG_TORQUE_SCALE_Y] <= RESET_TORQUE_SCALE_Y;
            r_scale[REG_TORQUE_SCALE_Z] <= RESET_TORQUE_SCALE_Z;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORCE_SCALE_X:  r_scale[REG_FORCE_SCALE_X]  <= i_cfg_data;
                REG_FORCE_SCALE_Y:  r_scale[REG_FORCE_SCALE_Y]  <= i_cfg_data;
                REG_FORCE_SCALE_Z:  r_scale[REG_FORCE_SCALE_Z]  <= i_cfg_data;
                REG_TORQUE_SCALE_X: r_scale[REG_TORQUE_SCALE_X] <= i_cfg_data;
                REG_TORQUE_SCALE_Y: r_scale[REG_TORQUE_SCALE_Y] <= i_cfg_data;
                REG_TORQUE_SCALE_Z: r_scale[REG_TORQUE_SCALE_Z] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_force    <= '0;
            r_raw_torque   <= '0;
            r_force_seen   <= 1'b0;
            r_torque_seen  <= 1'b0;
            r_tare_pending <= 1'b0;
            r_flight       <= '0;
            r_taken        <= '0;
        end else begin
            r_flight <= {r_flight[STAGES-2:0], accept && wrench};
            r_taken  <= {r_taken[STAGES-2:0],  accept && wrench && n_tare_pending};
            if (accept) begin
                r_raw_force  <= n_raw_force;
                r_raw_torque <= n_raw_torque;
                if (wrench) begin
                    // The pending tare, if any, is consumed by this wrench.
                    r_force_seen   <= 1'b0;
                    r_torque_seen  <= 1'b0;
                    r_tare_pending <= 1'b0;
                end else begin
                    r_force_seen   <= n_force_seen;
                    r_torque_seen  <= n_torque_seen;
                    r_tare_pending <= n_tare_pending;
                end
            end
        end
    end

    // The lanes multiply the words as updated by the completing frame.
    assign lane_ctrl.launch  = accept && wrench;
    assign lane_ctrl.capture = r_flight[1] && r_taken[1];

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        fts_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lane_ctrl),
            .i_raw    ((g < NUM_WORDS) ? n_raw_force[g % NUM_WORDS]
                                       : n_raw_torque[g % NUM_WORDS]),
            .i_scale  (r_scale[g]),
            .i_negate ((g % NUM_WORDS) == 0),
            .o_value  (wrench_out.axis[g])
        );
    end

    assign wrench_out.tare_taken = r_taken[STAGES-1];

    fts_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_flight[STAGES-1]),
        .i_wrench    (wrench_out),
        .i_pop_ready (i_m_tready),
        .o_valid     (o_m_tvalid),
        .o_data      (o_m_tdata),
        .o_count     (fifo_count)
    );

`ifndef ASSERT_OFF
    a_seen_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_force_seen && r_torque_seen))
        else $error("both seen flags held without a wrench");

    a_tare_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wrench && n_tare_pending) |=> !r_tare_pending)
        else $error("tare request survived the wrench that took it");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the force/torque CAN wrench decoder
// Drives CAN frame requests into the slave stream, predicts every wrench that
// the frames should produce and compares the master stream against it, field
// by field, under random idling on both sides and several scale settings.
// ----------------------------------------------------------------------------
module testbench;

    import fts_pkg::*;

    // Run shape.
    localparam int  CYCLE_LIMIT   = 100000;
    localparam int  DRAIN_LIMIT   = 1000;
    localparam int  SETTLE_CYCLES = 12;
    localparam int  NUM_PHASES    = 5;
    localparam int  PHASE_FRAMES  = 78;
    localparam int  LONG_HOLD     = 64;

    // Fixed-point scaling: 16-bit raw words against a 2^15 full scale.
    localparam int     ROUND_SHIFT = 15;
    localparam longint ROUND_BIAS  = 64'sd16384;
    localparam longint RAW_CENTER  = 64'sd32768;
    localparam longint AXIS_LIMIT  = longint'(OUT_LIMIT);

    // Axes that leave the block negated.
    localparam int AXIS_FORCE_X  = 0;
    localparam int AXIS_TORQUE_X = 3;

    // Register indexes past the scale registers; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 16'hFFFF;
    localparam logic [SCALE_W-1:0] SCALE_MIN = 16'h0000;

    // One CAN frame as it travels on the slave tdata, frame_id in the low bits.
    typedef struct packed {
        logic                 tare;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     len;
        logic [ID_W-1:0]      id;
    } t_can_frame;

    // One line of the directed plan: either a register write or a frame,
    // the latter with a hand-computed wrench where one is easy to read off.
    typedef struct {
        bit                   is_write;
        t_can_frame           frame;
        bit                   typed;
        t_wrench              want;
        logic [CFG_IDX_W-1:0] idx;
        logic [SCALE_W-1:0]   value;
    } t_plan_row;

    // Clock, reset and block ports. Every input has a known value from time 0.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  m_tready    = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_cfg_ready;

    // Shared between the stimulus and the receiver.
    logic    quiet        = 1'b0;   // no idling on either side
    logic    hold_request = 1'b0;   // ask the receiver for one long hold-off
    int      fails        = 0;
    int      cycle_count  = 0;
    t_wrench pending_wrenches[$];

    // Predictor state: a private copy of the scales and the decoder state.
    logic [SCALE_W-1:0] scale_reg  [NUM_AXES];
    logic [RAW_W-1:0]   raw_force  [NUM_WORDS];
    logic [RAW_W-1:0]   raw_torque [NUM_WORDS];
    bit                 force_seen;
    bit                 torque_seen;
    bit                 tare_armed;
    longint             tare_offset[NUM_AXES];

    t_plan_row plan[$];

    string axis_name[NUM_AXES] = '{"force_x", "force_y", "force_z",
                                   "torque_x", "torque_y", "torque_z"};

    ft_sensor_can_wrench_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic longint clamp_axis(longint v);
        if (v > AXIS_LIMIT)
            return AXIS_LIMIT;
        if (v < -AXIS_LIMIT)
            return -AXIS_LIMIT;
        return v;
    endfunction

    // (raw - 32768) * scale in 1/256 units, rounded half up, then clamped.
    // The arithmetic shift of a signed value is a floor division.
    function automatic longint scale_raw(logic [RAW_W-1:0] raw, logic [SCALE_W-1:0] sc);
        longint prod;
        prod = (longint'(raw) - RAW_CENTER) * longint'(sc);
        return clamp_axis(((prod <<< FRACTION_BITS) + ROUND_BIAS) >>> ROUND_SHIFT);
    endfunction

    // Only floor(len/2) words are written, never more than three; the rest
    // keep whatever an earlier frame left there.
    function automatic void unpack_words(ref logic [RAW_W-1:0] words[NUM_WORDS],
                                         input t_can_frame f);
        int count;
        count = int'(f.len) / 2;
        if (count > NUM_WORDS)
            count = NUM_WORDS;
        for (int i = 0; i < count; i++)
            words[i] = f.payload[RAW_W*i +: RAW_W];
    endfunction

    // Applies one accepted frame to the predictor state. Returns 1 with the
    // wrench in w when the frame completes a force/torque pair.
    function automatic bit decode_frame(input t_can_frame f, output t_wrench w);
        longint scaled[NUM_AXES];
        longint v;
        w = '0;
        // A tare request latches whatever the identifier is.
        if (f.tare)
            tare_armed = 1'b1;
        if (f.id == FORCE_ID) begin
            unpack_words(raw_force, f);
            force_seen = 1'b1;
        end else if (f.id == TORQUE_ID) begin
            unpack_words(raw_torque, f);
            torque_seen = 1'b1;
        end
        if (!(force_seen && torque_seen))
            return 1'b0;
        force_seen  = 1'b0;
        torque_seen = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            scaled[i]             = scale_raw(raw_force[i], scale_reg[i]);
            scaled[i + NUM_WORDS] = scale_raw(raw_torque[i], scale_reg[i + NUM_WORDS]);
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            v = clamp_axis(scaled[i] - tare_offset[i]);
            if (i == AXIS_FORCE_X || i == AXIS_TORQUE_X)
                v = -v;
            w.axis[i] = v[OUT_W-1:0];
        end
        // The capturing wrench still carries the old tare; the new one
        // takes effect from the next wrench on.
        w.tare_taken = tare_armed;
        if (tare_armed) begin
            for (int i = 0; i < NUM_AXES; i++)
                tare_offset[i] = scaled[i];
            tare_armed = 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: checks every accepted wrench against the oldest expectation
    // and decides tready for the next cycle. Counters here are private to
    // this process.
    // ------------------------------------------------------------------------

    int rx_wait  = 0;
    bit rx_held  = 1'b0;

    task automatic check_wrench(input logic [OUT_DATA_W-1:0] data);
        t_wrench got;
        t_wrench exp;
        got = t_wrench'(data[OUT_DATA_W-2:0]);
        if (pending_wrenches.size() == 0) begin
            $error("wrench received with none expected");
            fails++;
        end else begin
            exp = pending_wrenches.pop_front();
            for (int i = 0; i < NUM_AXES; i++) begin
                if (got.axis[i] !== exp.axis[i]) begin
                    $error("%s mismatch: expected %0d, got %0d", axis_name[i],
                           $signed(exp.axis[i]), $signed(got.axis[i]));
                    fails++;
                end
            end
            if (got.tare_taken !== exp.tare_taken) begin
                $error("tare_taken mismatch: expected %0d, got %0d",
                       exp.tare_taken, got.tare_taken);
                fails++;
            end
        end
        if (data[OUT_DATA_W-1] !== 1'b0) begin
            $error("pad mismatch: expected 0, got %0d", data[OUT_DATA_W-1]);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (o_m_tvalid && m_tready)
            check_wrench(o_m_tdata);
        // One long hold-off on request lets the result queue fill up and
        // pushes back on the slave side; otherwise short random bursts.
        if (rx_wait > 0)
            rx_wait--;
        else if (hold_request && !rx_held) begin
            rx_held = 1'b1;
            rx_wait = LONG_HOLD;
        end else if (!quiet && $urandom_range(0, 4) == 0)
            rx_wait = $urandom_range(1, 3);
        m_tready <= (rx_wait == 0);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one frame request, possibly after a short gap, and waits for it
    // to be taken. Valid stays high afterwards so back-to-back requests need
    // no extra edge. The expected wrench is queued when the frame is taken.
    task automatic send_frame(input t_can_frame f, input bit typed, input t_wrench want);
        t_wrench w;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        if (decode_frame(f, w))
            pending_wrenches.push_back(typed ? want : w);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx < NUM_AXES)
            scale_reg[idx] = val;
    endtask

    // Stops the sender, waits for every expected wrench, then lets the
    // pipeline run empty so that a register write cannot hit a frame.
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_wrenches.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_wrenches.size() != 0) begin
            $error("%0d expected wrenches never arrived", pending_wrenches.size());
            fails++;
            pending_wrenches.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_can_frame make_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                              logic [PAYLOAD_W-1:0] payload, logic tare);
        t_can_frame f;
        f.id      = id;
        f.len     = len;
        f.payload = payload;
        f.tare    = tare;
        return f;
    endfunction

    function automatic t_wrench make_wrench(int fx, int fy, int fz,
                                            int tx, int ty, int tz, logic taken);
        t_wrench w;
        w.axis[0]    = fx[OUT_W-1:0];
        w.axis[1]    = fy[OUT_W-1:0];
        w.axis[2]    = fz[OUT_W-1:0];
        w.axis[3]    = tx[OUT_W-1:0];
        w.axis[4]    = ty[OUT_W-1:0];
        w.axis[5]    = tz[OUT_W-1:0];
        w.tare_taken = taken;
        return w;
    endfunction

    function automatic void plan_frame(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                       logic [PAYLOAD_W-1:0] payload, logic tare);
        t_plan_row r;
        r = '{default: '0};
        r.frame = make_frame(id, len, payload, tare);
        plan.push_back(r);
    endfunction

    function automatic void plan_checked(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                         logic [PAYLOAD_W-1:0] payload, logic tare,
                                         t_wrench want);
        t_plan_row r;
        r = '{default: '0};
        r.frame = make_frame(id, len, payload, tare);
        r.typed = 1'b1;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
        t_plan_row r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.value    = val;
        plan.push_back(r);
    endfunction

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // A sensor frame with random content: mostly a full eight-byte frame,
    // sometimes any length code the field can carry, now and then a tare.
    function automatic t_can_frame sensor_frame(logic [ID_W-1:0] id);
        logic [LEN_W-1:0] len;
        len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'(8);
        return make_frame(id, len, rand_payload(), $urandom_range(0, 11) == 0);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        logic [SCALE_W-1:0] reset_scale[NUM_AXES];
        bit                 wrote;
        int                 sent;
        int                 pick;
        t_can_frame         f;
        logic [ID_W-1:0]    first_id;
        logic [SCALE_W-1:0] val;

        reset_scale = '{RESET_FORCE_SCALE_X, RESET_FORCE_SCALE_Y, RESET_FORCE_SCALE_Z,
                        RESET_TORQUE_SCALE_X, RESET_TORQUE_SCALE_Y, RESET_TORQUE_SCALE_Z};
        for (int i = 0; i < NUM_AXES; i++) begin
            scale_reg[i]   = reset_scale[i];
            tare_offset[i] = 0;
        end
        for (int i = 0; i < NUM_WORDS; i++) begin
            raw_force[i]  = '0;
            raw_torque[i] = '0;
        end
        force_seen  = 1'b0;
        torque_seen = 1'b0;
        tare_armed  = 1'b0;

        // Directed plan. With reset scales and no tare, centered words give
        // an all-zero wrench, and zero words give minus the full scale in
        // 1/256 units on every axis (x axes come out positive).
        plan_frame(11'h000, 4'd8, 64'h0, 1'b0);
        plan_frame(FORCE_ID, 4'd8, 64'h8000_8000_8000_8000, 1'b0);
        plan_checked(TORQUE_ID, 4'd8, 64'h8000_8000_8000_8000, 1'b0,
                     make_wrench(0, 0, 0, 0, 0, 0, 1'b0));
        plan_frame(FORCE_ID, 4'd8, 64'h0, 1'b0);
        plan_checked(TORQUE_ID, 4'd8, 64'h0, 1'b0,
                     make_wrench(400896, -454656, -543232, 9472, -9472, -5888, 1'b0));
        plan_frame(FORCE_ID, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // Length above eight is capped at three words like any other.
        plan_frame(TORQUE_ID, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // A tare request on a foreign identifier still latches.
        plan_frame(11'h7FF, 4'd15, rand_payload(), 1'b1);
        // Empty and one-byte frames write no word but still count as seen.
        plan_frame(FORCE_ID, 4'd0, rand_payload(), 1'b0);
        plan_frame(TORQUE_ID, 4'd1, rand_payload(), 1'b0);
        // Short frames, torque first this time.
        plan_frame(TORQUE_ID, 4'd2, rand_payload(), 1'b0);
        plan_frame(FORCE_ID, 4'd3, rand_payload(), 1'b0);
        // A repeated force frame, then a tare on the completing frame itself.
        plan_frame(FORCE_ID, 4'd5, rand_payload(), 1'b0);
        plan_frame(FORCE_ID, 4'd4, rand_payload(), 1'b0);
        plan_frame(TORQUE_ID, 4'd7, rand_payload(), 1'b1);
        // Neighbors of the sensor identifiers are foreign.
        plan_frame(11'h3D9, 4'd8, rand_payload(), 1'b0);
        plan_frame(11'h3DC, 4'd8, rand_payload(), 1'b0);

        // Largest scales: zero words capture a tare at the negative limit,
        // then all-ones words saturate the tared value at the positive one.
        for (int i = 0; i < NUM_AXES; i++)
            plan_write(t_reg_idx'(i), SCALE_MAX);
        plan_frame(FORCE_ID, 4'd8, 64'h0, 1'b1);
        plan_frame(TORQUE_ID, 4'd8, 64'h0, 1'b0);
        plan_frame(FORCE_ID, 4'd6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        plan_checked(TORQUE_ID, 4'd6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                     make_wrench(-OUT_LIMIT, OUT_LIMIT, OUT_LIMIT,
                                 -OUT_LIMIT, OUT_LIMIT, OUT_LIMIT, 1'b0));
        plan_frame(FORCE_ID, 4'd8, 64'h0, 1'b0);
        plan_checked(TORQUE_ID, 4'd8, 64'h0, 1'b0, make_wrench(0, 0, 0, 0, 0, 0, 1'b0));

        // Zero scales read zero; minus the stored negative tare that is the
        // positive limit. Writes past the last register must change nothing.
        for (int i = 0; i < NUM_AXES; i++)
            plan_write(t_reg_idx'(i), SCALE_MIN);
        plan_write(IDX_SPARE_LO, SCALE_MAX);
        plan_write(IDX_SPARE_HI, SCALE_MAX);
        plan_frame(FORCE_ID, 4'd8, rand_payload(), 1'b0);
        plan_checked(TORQUE_ID, 4'd8, rand_payload(), 1'b0,
                     make_wrench(-OUT_LIMIT, OUT_LIMIT, OUT_LIMIT,
                                 -OUT_LIMIT, OUT_LIMIT, OUT_LIMIT, 1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the plan. Before a group of register writes the block is
        // drained; frames after the group drop the write valid.
        wrote = 1'b0;
        foreach (plan[n]) begin
            if (plan[n].is_write) begin
                if (!wrote)
                    wait_idle();
                wrote = 1'b1;
                write_reg(plan[n].idx, plan[n].value);
            end else begin
                wrote = 1'b0;
                cfg_valid <= 1'b0;
                send_frame(plan[n].frame, plan[n].typed, plan[n].want);
            end
        end
        wait_idle();

        // Random phases, each with its own scale setting. The second one
        // holds the receiver off for a long stretch; the last one runs
        // without any idling.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiet <= (ph == NUM_PHASES - 1);
            for (int i = 0; i < NUM_AXES; i++) begin
                case ($urandom_range(0, 3))
                    0: val = SCALE_MIN;
                    1: val = SCALE_MAX;
                    2: val = reset_scale[i];
                    default: val = SCALE_W'($urandom);
                endcase
                write_reg(t_reg_idx'(i), val);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO,
                          SCALE_W'($urandom));
            cfg_valid <= 1'b0;
            if (ph == 1)
                hold_request <= 1'b1;

            sent = 0;
            while (sent < PHASE_FRAMES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // Well-formed pair in either order.
                    first_id = $urandom_range(0, 1) ? FORCE_ID : TORQUE_ID;
                    send_frame(sensor_frame(first_id), 1'b0, '0);
                    send_frame(sensor_frame(first_id ^ 11'h001), 1'b0, '0);
                    sent += 2;
                end else if (pick < 85) begin
                    // Noise on the bus: any identifier, length and payload.
                    f = make_frame(ID_W'($urandom), LEN_W'($urandom), rand_payload(),
                                   1'($urandom_range(0, 1)));
                    send_frame(f, 1'b0, '0);
                    if (f.id == FORCE_ID || f.id == TORQUE_ID)
                        sent++;
                end else begin
                    // A lone frame that breaks the pairing.
                    send_frame(sensor_frame($urandom_range(0, 1) ? FORCE_ID : TORQUE_ID),
                               1'b0, '0);
                    sent++;
                end
            end
            wait_idle();
        end

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
